@@ hw/rtl/lsds_pkg.sv @@
package lsds_pkg;

  localparam int unsigned KEY_W         = 31;
  localparam int unsigned TAG_W         = 16;
  localparam int unsigned DIGIT_W       = 4;
  localparam int unsigned RADIX_BUCKETS = 10;
  localparam logic [DIGIT_W-1:0] LAST_BUCKET = 4'd9;

  // floor(x / 10) == (x * RECIP_TEN) >> DIV_SHIFT for every x below 2**32
  localparam logic [31:0]  RECIP_TEN = 32'hCCCC_CCCD;
  localparam int unsigned  DIV_SHIFT = 35;
  localparam int unsigned  PROD_W    = KEY_W + 32;

  // One stored record: key, tag, remaining quotient and the current digit
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [TAG_W-1:0]   tag;
    logic [KEY_W-1:0]   quot;
    logic [DIGIT_W-1:0] digit;
  } rec_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_CNT_RD,
    ST_CNT_MUL,
    ST_CNT_WB,
    ST_PREFIX,
    ST_SCT_RD,
    ST_SCT_WR,
    ST_MAX_MUL,
    ST_MAX_UPD,
    ST_EM_RD,
    ST_EM_LD,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic load_en;
    logic clr_set;
    logic clr_fill;
    logic rd_en;
    logic idx_clr;
    logic idx_inc;
    logic cnt_mul;
    logic cnt_wb;
    logic pref_clr;
    logic pref_step;
    logic sct_wr;
    logic flip_bank;
    logic max_mul;
    logic max_upd;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic maxq_zero;
    logic idx_last;
    logic pref_last;
    logic out_free;
  } status_t;

endpackage

@@ hw/rtl/lsds_if.sv @@
interface lsds_rec_if;
  logic                           valid;
  logic                           ready;
  logic [lsds_pkg::KEY_W-1:0]     sort_key;
  logic [lsds_pkg::TAG_W-1:0]     payload_tag;
  logic                           final_record;

  modport source (output valid, sort_key, payload_tag, final_record, input ready);
  modport sink   (input valid, sort_key, payload_tag, final_record, output ready);
endinterface

interface lsds_res_if;
  logic                           valid;
  logic                           ready;
  logic [lsds_pkg::KEY_W-1:0]     sorted_key;
  logic [lsds_pkg::TAG_W-1:0]     sorted_tag;
  logic                           end_of_run;
  logic                           overflow_seen;

  modport source (output valid, sorted_key, sorted_tag, end_of_run, overflow_seen,
                  input ready);
  modport sink   (input valid, sorted_key, sorted_tag, end_of_run, overflow_seen,
                  output ready);
endinterface

interface lsds_cfg_if;
  logic valid;
  logic ready;
  logic descending_order;

  modport source (output valid, descending_order, input ready);
  modport sink   (input valid, descending_order, output ready);
endinterface

@@ hw/rtl/lsds_datapath.sv @@
module lsds_datapath #(
  parameter int unsigned MAX_RECORDS = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lsds_pkg::cmd_t              cmd_i,
  output lsds_pkg::status_t           status_o,
  input  logic [lsds_pkg::KEY_W-1:0]  in_key_i,
  input  logic [lsds_pkg::TAG_W-1:0]  in_tag_i,
  input  logic                        cfg_we_i,
  input  logic                        cfg_desc_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [lsds_pkg::KEY_W-1:0]  out_key_o,
  output logic [lsds_pkg::TAG_W-1:0]  out_tag_o,
  output logic                        out_end_o,
  output logic                        out_ovf_o
);

  localparam int unsigned AW = $clog2(MAX_RECORDS);
  localparam int unsigned CW = $clog2(MAX_RECORDS + 1);

  lsds_pkg::rec_t mem0 [MAX_RECORDS];
  lsds_pkg::rec_t mem1 [MAX_RECORDS];
  lsds_pkg::rec_t rd0_q, rd1_q, rd_rec, ld_rec, wb_rec;

  logic [CW-1:0] count_q, idx_q, pos_q;
  logic [CW-1:0] fill_q  [lsds_pkg::RADIX_BUCKETS];
  logic [CW-1:0] start_q [lsds_pkg::RADIX_BUCKETS];
  logic [lsds_pkg::DIGIT_W-1:0] pref_q, bucket;
  logic          ovf_q, bank_q, desc_q, full, load_wr;
  logic [lsds_pkg::KEY_W-1:0]  maxq_q, mul_a, quot, q10, diff;
  logic [lsds_pkg::PROD_W-1:0] prod_q;
  logic [lsds_pkg::DIGIT_W-1:0] digit;
  logic [AW-1:0] sct_addr;
  logic          we0, we1;
  logic [AW-1:0] wa0, wa1;
  lsds_pkg::rec_t wd0, wd1;
  logic          out_valid_q, out_end_q, out_ovf_q;
  logic [lsds_pkg::KEY_W-1:0] out_key_q;
  logic [lsds_pkg::TAG_W-1:0] out_tag_q;

  assign full    = (count_q == CW'(MAX_RECORDS));
  assign load_wr = cmd_i.load_en && !full;
  assign rd_rec  = bank_q ? rd1_q : rd0_q;

  // divide by ten through the reciprocal product
  assign mul_a = cmd_i.max_mul ? maxq_q : rd_rec.quot;
  assign quot  = lsds_pkg::KEY_W'(prod_q >> lsds_pkg::DIV_SHIFT);
  assign q10   = (quot << 3) + (quot << 1);
  assign diff  = rd_rec.quot - q10;
  assign digit = diff[lsds_pkg::DIGIT_W-1:0];

  assign ld_rec = '{key: in_key_i, tag: in_tag_i, quot: in_key_i, digit: '0};
  always_comb begin
    wb_rec       = rd_rec;
    wb_rec.quot  = quot;
    wb_rec.digit = digit;
  end

  assign sct_addr = start_q[rd_rec.digit][AW-1:0];

  always_comb begin
    we0 = 1'b0;
    wa0 = count_q[AW-1:0];
    wd0 = ld_rec;
    we1 = 1'b0;
    wa1 = idx_q[AW-1:0];
    wd1 = wb_rec;
    if (load_wr) begin
      we0 = 1'b1;
    end else if (cmd_i.cnt_wb) begin
      if (bank_q) begin
        we1 = 1'b1;
      end else begin
        we0 = 1'b1;
        wa0 = idx_q[AW-1:0];
        wd0 = wb_rec;
      end
    end else if (cmd_i.sct_wr) begin
      if (bank_q) begin
        we0 = 1'b1;
        wa0 = sct_addr;
        wd0 = rd_rec;
      end else begin
        we1 = 1'b1;
        wa1 = sct_addr;
        wd1 = rd_rec;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we0) mem0[wa0] <= wd0;
    if (cmd_i.rd_en) rd0_q <= mem0[idx_q[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (we1) mem1[wa1] <= wd1;
    if (cmd_i.rd_en) rd1_q <= mem1[idx_q[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cnt_mul || cmd_i.max_mul) prod_q <= mul_a * lsds_pkg::RECIP_TEN;
  end

  assign bucket = desc_q ? (lsds_pkg::LAST_BUCKET - pref_q) : pref_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
      maxq_q  <= '0;
      bank_q  <= 1'b0;
      desc_q  <= 1'b0;
      idx_q   <= '0;
      pref_q  <= '0;
      pos_q   <= '0;
    end else begin
      if (cfg_we_i) desc_q <= cfg_desc_i;
      if (cmd_i.clr_set) begin
        count_q <= '0;
        ovf_q   <= 1'b0;
        maxq_q  <= '0;
        bank_q  <= 1'b0;
      end else begin
        if (load_wr) begin
          count_q <= count_q + 1'b1;
          if (in_key_i > maxq_q) maxq_q <= in_key_i;
        end
        if (cmd_i.load_en && full) ovf_q <= 1'b1;
        if (cmd_i.max_upd) maxq_q <= quot;
        if (cmd_i.flip_bank) bank_q <= ~bank_q;
      end
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.pref_clr) begin
        pref_q <= '0;
        pos_q  <= '0;
      end else if (cmd_i.pref_step) begin
        pref_q <= pref_q + 1'b1;
        pos_q  <= pos_q + fill_q[bucket];
      end
    end
  end

  // bucket counters and running start offsets
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_fill) begin
      for (int b = 0; b < lsds_pkg::RADIX_BUCKETS; b++) fill_q[b] <= '0;
    end else if (cmd_i.cnt_wb) begin
      fill_q[digit] <= fill_q[digit] + 1'b1;
    end
    if (cmd_i.pref_step) begin
      start_q[bucket] <= pos_q;
    end else if (cmd_i.sct_wr) begin
      start_q[rd_rec.digit] <= start_q[rd_rec.digit] + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_key_q <= rd_rec.key;
      out_tag_q <= rd_rec.tag;
      out_end_q <= status_o.idx_last;
      out_ovf_q <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_key_o   = out_key_q;
  assign out_tag_o   = out_tag_q;
  assign out_end_o   = out_end_q;
  assign out_ovf_o   = out_ovf_q;

  assign status_o.maxq_zero = (maxq_q == '0);
  assign status_o.idx_last  = (CW'(idx_q + 1'b1) == count_q);
  assign status_o.pref_last = (pref_q == lsds_pkg::LAST_BUCKET);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  a_ovf_on_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load_en && full && !cmd_i.clr_set) |=> ovf_q)
    else $error("dropped load did not raise overflow");

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_wb |-> (digit <= lsds_pkg::LAST_BUCKET))
    else $error("digit out of range");

  a_scatter_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sct_wr |-> (start_q[rd_rec.digit] < count_q))
    else $error("scatter address beyond record count");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("pending result overwritten");

endmodule

@@ hw/rtl/lsds_ctrl.sv @@
module lsds_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_final_i,
  output logic              in_ready_o,
  input  lsds_pkg::status_t status_i,
  output lsds_pkg::cmd_t    cmd_o
);

  lsds_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lsds_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      lsds_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_en = 1'b1;
          if (in_final_i) state_d = lsds_pkg::ST_CHECK;
        end
      end
      lsds_pkg::ST_CHECK: begin
        cmd_o.idx_clr = 1'b1;
        if (status_i.maxq_zero) begin
          state_d = lsds_pkg::ST_EM_RD;
        end else begin
          cmd_o.clr_fill = 1'b1;
          cmd_o.pref_clr = 1'b1;
          state_d        = lsds_pkg::ST_CNT_RD;
        end
      end
      lsds_pkg::ST_CNT_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = lsds_pkg::ST_CNT_MUL;
      end
      lsds_pkg::ST_CNT_MUL: begin
        cmd_o.cnt_mul = 1'b1;
        state_d       = lsds_pkg::ST_CNT_WB;
      end
      lsds_pkg::ST_CNT_WB: begin
        cmd_o.cnt_wb = 1'b1;
        if (status_i.idx_last) begin
          cmd_o.idx_clr = 1'b1;
          state_d       = lsds_pkg::ST_PREFIX;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = lsds_pkg::ST_CNT_RD;
        end
      end
      lsds_pkg::ST_PREFIX: begin
        cmd_o.pref_step = 1'b1;
        if (status_i.pref_last) state_d = lsds_pkg::ST_SCT_RD;
      end
      lsds_pkg::ST_SCT_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = lsds_pkg::ST_SCT_WR;
      end
      lsds_pkg::ST_SCT_WR: begin
        cmd_o.sct_wr = 1'b1;
        if (status_i.idx_last) begin
          state_d = lsds_pkg::ST_MAX_MUL;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = lsds_pkg::ST_SCT_RD;
        end
      end
      lsds_pkg::ST_MAX_MUL: begin
        cmd_o.max_mul   = 1'b1;
        cmd_o.flip_bank = 1'b1;
        cmd_o.idx_clr   = 1'b1;
        state_d         = lsds_pkg::ST_MAX_UPD;
      end
      lsds_pkg::ST_MAX_UPD: begin
        cmd_o.max_upd = 1'b1;
        state_d       = lsds_pkg::ST_CHECK;
      end
      lsds_pkg::ST_EM_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = lsds_pkg::ST_EM_LD;
      end
      lsds_pkg::ST_EM_LD: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (status_i.idx_last) begin
            state_d = lsds_pkg::ST_FINISH;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = lsds_pkg::ST_EM_RD;
          end
        end
      end
      lsds_pkg::ST_FINISH: begin
        cmd_o.clr_set = 1'b1;
        state_d       = lsds_pkg::ST_IDLE;
      end
      default: begin
        state_d = lsds_pkg::ST_IDLE;
      end
    endcase
  end

  a_load_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_en |-> (state_q == lsds_pkg::ST_IDLE))
    else $error("load outside idle");

  a_final_starts_sort: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_final_i) |=> (state_q == lsds_pkg::ST_CHECK))
    else $error("final word did not start the sort");

  a_pass_ends_in_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lsds_pkg::ST_MAX_MUL) |=> ##1 (state_q == lsds_pkg::ST_CHECK))
    else $error("digit pass did not return to check");

endmodule

@@ hw/rtl/lsd_decimal_radix_sorter.sv @@
// LSD decimal radix sorter.
// Channels: in_ch_i takes one record word (sort_key, payload_tag,
// final_record) per cycle while the block is idle; out_ch_o delivers the
// sorted words; cfg_ch_i writes descending_order (always ready).
// Loading: one word per cycle into record memory. Words beyond
// MAX_RECORDS are dropped and flagged in overflow_seen of the run.
// The word with final_record set starts the sort; input stays blocked until
// the finish state that follows the last sorted word's output-register load.
// Sorting, D decimal digits of the largest key: D digit passes;
//   each digit pass counts digits (read, multiply and write-back per
//   record, through the shared divide-by-ten multiplier), builds the ten
//   bucket offsets and scatters into the other memory bank (read, then
//   write per record, one memory port each way).
// Emission: each word is a registered memory read, then the output
// register load, end_of_run on the last. A stalled receiver simply holds the
// output register; the sequencer waits until it frees.
// Reset: set is emptied, overflow cleared, order ascending; record
// memories hold garbage until written and need no clearing pass.
module lsd_decimal_radix_sorter #(
  parameter int unsigned MAX_RECORDS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lsds_rec_if.sink    in_ch_i,
  lsds_res_if.source  out_ch_o,
  lsds_cfg_if.sink    cfg_ch_i
);

  lsds_pkg::cmd_t    cmd;
  lsds_pkg::status_t status;
  logic              in_ready;

  // configuration is a plain register write, never stalled
  assign cfg_ch_i.ready = 1'b1;
  assign in_ch_i.ready  = in_ready;

  lsds_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch_i.valid),
    .in_final_i (in_ch_i.final_record),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lsds_datapath #(
    .MAX_RECORDS (MAX_RECORDS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_key_i    (in_ch_i.sort_key),
    .in_tag_i    (in_ch_i.payload_tag),
    .cfg_we_i    (cfg_ch_i.valid),
    .cfg_desc_i  (cfg_ch_i.descending_order),
    .out_valid_o (out_ch_o.valid),
    .out_ready_i (out_ch_o.ready),
    .out_key_o   (out_ch_o.sorted_key),
    .out_tag_o   (out_ch_o.sorted_tag),
    .out_end_o   (out_ch_o.end_of_run),
    .out_ovf_o   (out_ch_o.overflow_seen)
  );

endmodule
